FILE: sv/rcrt_pkg.sv
// Shared types, constants and an elaboration-time function for the RC command
// rotate and throttle block. No dependencies.
package rcrt_pkg;

    localparam int IN_W    = 16;
    localparam int OUT_W   = 24;
    localparam int THR_W   = 16;
    localparam int KS_W    = 3;
    localparam int LVL_W   = 8;
    localparam int SUM_W   = THR_W + 2;
    localparam int PADDR_W = 3;
    localparam int APB_DW  = 32;

    // CORDIC datapath: stick values in 1/256 deg with 15 extra fraction bits
    localparam int VEC_W        = 34;
    localparam int ANG_W        = 34;
    localparam int STICK_SH     = 15;
    localparam int ATAN_W       = 30;
    localparam int ATAN_ENTRIES = 24;
    localparam int CNT_W        = $clog2(ATAN_ENTRIES);
    localparam int CORDIC_ITERATIONS_DEF = 16;

    // gain removal: 34 bit vector split in two halves against a Q28 inverse gain
    localparam int INV_W       = 28;
    localparam int GAIN_Q      = 30;
    localparam int DIVIDEND_SH = 58;
    localparam int SPLIT_W     = 17;
    localparam int OPA_W       = SPLIT_W + 1;
    localparam int PROD_W      = OPA_W + INV_W + 1;
    localparam int ACC_W       = 64;
    localparam int ROUND_SH    = 36;
    localparam int MUL_STEPS   = 4;

    localparam int QUEUE_DEPTH = 2;

    localparam logic signed [ANG_W-1:0] ANG_QUARTER = ANG_W'(64'd1 << 30);
    localparam logic signed [ANG_W-1:0] ANG_HALF    = ANG_W'(64'd1 << 31);

    localparam logic signed [IN_W-1:0] KEY_STOP_A = 16'sd100;
    localparam logic signed [IN_W-1:0] KEY_UP     = 16'sd101;
    localparam logic signed [IN_W-1:0] KEY_DOWN   = 16'sd102;
    localparam logic signed [IN_W-1:0] KEY_STOP_B = 16'sd103;
    localparam logic signed [IN_W-1:0] KEY_START  = 16'sd104;

    localparam logic signed [LVL_W-1:0] LVL_MAX  = 8'sd110;
    localparam logic signed [LVL_W-1:0] LVL_MIN  = -8'sd50;
    localparam logic signed [SUM_W-1:0] LVL_STEP = 18'sd15;
    localparam logic signed [SUM_W-1:0] THR_MAX  = 18'sd65535;

    // key operation; the value doubles as the reported key state
    typedef enum logic [KS_W-1:0] {
        OP_NONE    = 3'd0,
        OP_STOP100 = 3'd1,
        OP_STOP103 = 3'd2,
        OP_UP      = 3'd3,
        OP_DOWN    = 3'd4,
        OP_START   = 3'd5
    } key_op_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [ANG_W-1:0] z;
        key_op_t                 op;
    } cmd_t;

    // atan(2^-i) in 2^-32 turn
    localparam logic [ATAN_W-1:0] ATAN_TURNS [ATAN_ENTRIES] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81
    };

    // inverse CORDIC gain in Q28, evaluated at elaboration only
    function automatic logic [INV_W-1:0] inv_gain(input int steps);
        logic [63:0]            a2;
        logic [63:0]            n;
        logic [63:0]            root;
        logic [63:0]            bitv;
        logic [63:0]            rem;
        logic [DIVIDEND_SH:0]   q;
        a2 = 64'd1 << GAIN_Q;
        for (int i = 0; i < ATAN_ENTRIES; i++) begin
            if (i < steps) begin
                a2 = a2 + (a2 >> (2 * i));
            end
        end
        n    = a2 << GAIN_Q;
        root = '0;
        bitv = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (bitv > n) begin
                bitv = bitv >> 2;
            end
        end
        for (int k = 0; k < 32; k++) begin
            if (bitv != 0) begin
                if (n >= root + bitv) begin
                    n    = n - (root + bitv);
                    root = (root >> 1) + bitv;
                end else begin
                    root = root >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        if (root == 0) begin
            root = 64'd1;
        end
        // restoring long division of 2^58 by root
        rem = '0;
        q   = '0;
        for (int b = DIVIDEND_SH; b >= 0; b--) begin
            rem = {rem[62:0], (b == DIVIDEND_SH)};
            if (rem >= root) begin
                rem  = rem - root;
                q[b] = 1'b1;
            end
        end
        return q[INV_W-1:0];
    endfunction

endpackage

FILE: sv/rcrt_front.sv
// Front end: takes a packet, classifies the key code and prepares the
// folded CORDIC start vector. Depends on rcrt_pkg.
module rcrt_front (
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [rcrt_pkg::IN_W-1:0]     roll_stick,
    input  logic signed [rcrt_pkg::IN_W-1:0]     pitch_stick,
    input  logic signed [rcrt_pkg::IN_W-1:0]     key_code,
    input  logic        [rcrt_pkg::IN_W-1:0]     yaw_angle,
    output logic                                 push_valid,
    input  logic                                 push_ready,
    output rcrt_pkg::cmd_t                       push_item
);
    import rcrt_pkg::*;

    logic signed [VEC_W-1:0] roll_sc;
    logic signed [VEC_W-1:0] pitch_sc;
    logic signed [ANG_W-1:0] z_raw;
    logic                    fold_pos;
    logic                    fold_neg;
    key_op_t                 op;

    assign roll_sc  = VEC_W'(roll_stick) <<< STICK_SH;
    assign pitch_sc = VEC_W'(pitch_stick) <<< STICK_SH;
    assign z_raw    = ANG_W'($signed({yaw_angle, {IN_W{1'b0}}}));
    assign fold_pos = z_raw > ANG_QUARTER;
    assign fold_neg = z_raw < -ANG_QUARTER;

    always_comb
    begin
        unique case (key_code)
            KEY_STOP_A: op = OP_STOP100;
            KEY_STOP_B: op = OP_STOP103;
            KEY_UP:     op = OP_UP;
            KEY_DOWN:   op = OP_DOWN;
            KEY_START:  op = OP_START;
            default:    op = OP_NONE;
        endcase
    end

    // sticks are negated; a half turn fold negates them again
    always_comb
    begin
        push_item.op = op;
        if (fold_pos || fold_neg)
        begin
            push_item.x = roll_sc;
            push_item.y = pitch_sc;
        end
        else
        begin
            push_item.x = -roll_sc;
            push_item.y = -pitch_sc;
        end
        if (fold_pos)
        begin
            push_item.z = z_raw - ANG_HALF;
        end
        else if (fold_neg)
        begin
            push_item.z = z_raw + ANG_HALF;
        end
        else
        begin
            push_item.z = z_raw;
        end
    end

    assign push_valid = in_valid;
    assign in_stall   = !push_ready;

endmodule

FILE: sv/rcrt_queue.sv
// Short request queue between front and back end.
// Depends on rcrt_pkg (cmd_t, QUEUE_DEPTH).
module rcrt_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  rcrt_pkg::cmd_t push_item,
    output logic           pop_valid,
    input  logic           pop,
    output rcrt_pkg::cmd_t pop_item
);
    import rcrt_pkg::*;

    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t               entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               do_push;
    logic               do_pop;

    assign push_ready = count_reg != COUNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_item   = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: sv/rcrt_cordic.sv
// Iterative CORDIC rotation, one step per cycle, then gain removal on a
// shared 18x29 multiplier over x and y halves. Depends on rcrt_pkg.
module rcrt_cordic #(
    parameter int CORDIC_ITERATIONS = rcrt_pkg::CORDIC_ITERATIONS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [rcrt_pkg::VEC_W-1:0]   x_in,
    input  logic signed [rcrt_pkg::VEC_W-1:0]   y_in,
    input  logic signed [rcrt_pkg::ANG_W-1:0]   z_in,
    output logic                                done,
    output logic signed [rcrt_pkg::OUT_W-1:0]   roll_res,
    output logic signed [rcrt_pkg::OUT_W-1:0]   pitch_res
);
    import rcrt_pkg::*;

    localparam int STEPS = (CORDIC_ITERATIONS < ATAN_ENTRIES) ? CORDIC_ITERATIONS : ATAN_ENTRIES;
    localparam logic [INV_W-1:0]        INV        = inv_gain(STEPS);
    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(64'd1 << (ROUND_SH - 1));
    localparam logic signed [ACC_W-1:0] SAT_MAX    = ACC_W'((64'd1 << (OUT_W - 1)) - 64'd1);
    localparam logic signed [ACC_W-1:0] SAT_MIN    = -ACC_W'(64'd1 << (OUT_W - 1));

    // multiplier operand codes
    localparam logic [1:0] OPD_XLO = 2'd0;
    localparam logic [1:0] OPD_XHI = 2'd1;
    localparam logic [1:0] OPD_YLO = 2'd2;
    localparam logic [1:0] OPD_YHI = 2'd3;

    typedef enum logic [1:0] {
        C_IDLE,
        C_ROT,
        C_MUL
    } c_state_t;

    c_state_t                 state_reg;
    logic signed [VEC_W-1:0]  x_reg;
    logic signed [VEC_W-1:0]  y_reg;
    logic signed [ANG_W-1:0]  z_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic signed [PROD_W-1:0] mul_reg;
    logic [1:0]               tag_reg;
    logic                     pv_reg;
    logic signed [ACC_W-1:0]  acc_x_reg;
    logic signed [ACC_W-1:0]  acc_y_reg;
    logic                     done_reg;

    logic signed [VEC_W-1:0]  dx;
    logic signed [VEC_W-1:0]  dy;
    logic signed [ANG_W-1:0]  atan_ext;
    logic signed [OPA_W-1:0]  opa;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  addend;

    function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] r;
        r = a >>> ROUND_SH;
        if (r > SAT_MAX)
        begin
            r = SAT_MAX;
        end
        else if (r < SAT_MIN)
        begin
            r = SAT_MIN;
        end
        return r[OUT_W-1:0];
    endfunction

    assign dx       = y_reg >>> cnt_reg;
    assign dy       = x_reg >>> cnt_reg;
    assign atan_ext = $signed({{(ANG_W - ATAN_W){1'b0}}, ATAN_TURNS[cnt_reg]});

    always_comb
    begin
        case (cnt_reg[1:0])
            OPD_XLO: opa = $signed({1'b0, x_reg[SPLIT_W-1:0]});
            OPD_XHI: opa = OPA_W'($signed(x_reg[VEC_W-1:SPLIT_W]));
            OPD_YLO: opa = $signed({1'b0, y_reg[SPLIT_W-1:0]});
            default: opa = OPA_W'($signed(y_reg[VEC_W-1:SPLIT_W]));
        endcase
    end

    assign prod = PROD_W'(opa) * PROD_W'($signed({1'b0, INV}));

    // odd tags carry the upper half of the vector
    assign addend = tag_reg[0] ? (ACC_W'(mul_reg) <<< SPLIT_W) : ACC_W'(mul_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            cnt_reg   <= '0;
            tag_reg   <= OPD_XLO;
            pv_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                C_IDLE:
                begin
                    if (start)
                    begin
                        x_reg     <= x_in;
                        y_reg     <= y_in;
                        z_reg     <= z_in;
                        cnt_reg   <= '0;
                        state_reg <= C_ROT;
                    end
                end
                C_ROT:
                begin
                    if (!z_reg[ANG_W-1])
                    begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - atan_ext;
                    end
                    else
                    begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + atan_ext;
                    end
                    if (cnt_reg == CNT_W'(STEPS - 1))
                    begin
                        cnt_reg   <= '0;
                        acc_x_reg <= ROUND_BIAS;
                        acc_y_reg <= ROUND_BIAS;
                        state_reg <= C_MUL;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                C_MUL:
                begin
                    if (cnt_reg < CNT_W'(MUL_STEPS))
                    begin
                        mul_reg <= prod;
                        tag_reg <= cnt_reg[1:0];
                        pv_reg  <= 1'b1;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    else
                    begin
                        pv_reg <= 1'b0;
                    end
                    if (pv_reg)
                    begin
                        if (tag_reg[1])
                        begin
                            acc_y_reg <= acc_y_reg + addend;
                        end
                        else
                        begin
                            acc_x_reg <= acc_x_reg + addend;
                        end
                        if (tag_reg == OPD_YHI)
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= C_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    assign done      = done_reg;
    assign roll_res  = round_sat(acc_x_reg);
    assign pitch_res = round_sat(acc_y_reg);

endmodule

FILE: sv/rcrt_back.sv
// Back end: runs the CORDIC on each queued request, applies the key
// operation to power level, throttle and flags, and holds the result.
// Depends on rcrt_pkg and rcrt_cordic.
module rcrt_back #(
    parameter int CORDIC_ITERATIONS = rcrt_pkg::CORDIC_ITERATIONS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_valid,
    output logic                               q_pop,
    input  rcrt_pkg::cmd_t                     q_item,
    input  logic [rcrt_pkg::THR_W-1:0]         throttle_base,
    input  logic [rcrt_pkg::THR_W-1:0]         motor_off_value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [rcrt_pkg::OUT_W-1:0]  roll_target,
    output logic signed [rcrt_pkg::OUT_W-1:0]  pitch_target,
    output logic [rcrt_pkg::THR_W-1:0]         throttle_out,
    output logic [rcrt_pkg::KS_W-1:0]          key_state,
    output logic                               stop_out,
    output logic                               start_out,
    output logic                               clear_integrators
);
    import rcrt_pkg::*;

    typedef enum logic [1:0] {
        B_IDLE,
        B_RUN,
        B_WAIT
    } b_state_t;

    b_state_t                 state_reg;
    key_op_t                  op_reg;
    logic signed [LVL_W-1:0]  level_reg;
    logic [THR_W-1:0]         throttle_reg;
    key_op_t                  key_state_reg;
    logic                     stop_reg;
    logic                     start_reg;
    logic                     out_valid_reg;
    logic signed [OUT_W-1:0]  roll_reg;
    logic signed [OUT_W-1:0]  pitch_reg;
    logic                     clear_reg;

    logic                     cord_done;
    logic signed [OUT_W-1:0]  cord_roll;
    logic signed [OUT_W-1:0]  cord_pitch;
    logic                     out_free;
    logic                     commit;

    logic signed [LVL_W-1:0]  level_next;
    logic [THR_W-1:0]         throttle_next;
    key_op_t                  key_state_next;
    logic                     stop_next;
    logic                     start_next;
    logic                     clear_next;

    function automatic logic [THR_W-1:0] level_throttle(
        input logic [THR_W-1:0]        base,
        input logic signed [LVL_W-1:0] lvl
    );
        logic signed [SUM_W-1:0] t;
        t = $signed({2'b00, base}) + SUM_W'(lvl) * LVL_STEP;
        if (t < 0)
        begin
            return '0;
        end
        else if (t > THR_MAX)
        begin
            return '1;
        end
        return t[THR_W-1:0];
    endfunction

    rcrt_cordic #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (q_pop),
        .x_in      (q_item.x),
        .y_in      (q_item.y),
        .z_in      (q_item.z),
        .done      (cord_done),
        .roll_res  (cord_roll),
        .pitch_res (cord_pitch)
    );

    assign q_pop    = (state_reg == B_IDLE) && q_valid;
    assign out_free = !out_valid_reg || !out_stall;
    assign commit   = (((state_reg == B_RUN) && cord_done) || (state_reg == B_WAIT)) && out_free;

    always_comb
    begin
        level_next     = level_reg;
        throttle_next  = throttle_reg;
        key_state_next = key_state_reg;
        stop_next      = stop_reg;
        start_next     = start_reg;
        clear_next     = 1'b0;
        unique case (op_reg) inside
            OP_STOP100, OP_STOP103:
            begin
                key_state_next = op_reg;
                stop_next      = 1'b1;
                start_next     = 1'b0;
                level_next     = '0;
                throttle_next  = motor_off_value;
                clear_next     = 1'b1;
            end
            OP_UP:
            begin
                key_state_next = OP_UP;
                stop_next      = 1'b0;
                level_next     = (level_reg >= LVL_MAX) ? LVL_MAX : level_reg + 8'sd1;
                throttle_next  = level_throttle(throttle_base, level_next);
            end
            OP_DOWN:
            begin
                key_state_next = OP_DOWN;
                stop_next      = 1'b0;
                level_next     = (level_reg <= LVL_MIN) ? LVL_MIN : level_reg - 8'sd1;
                throttle_next  = level_throttle(throttle_base, level_next);
            end
            OP_START:
            begin
                // arms only while not already started
                if (!start_reg)
                begin
                    key_state_next = OP_START;
                    start_next     = 1'b1;
                    stop_next      = 1'b1;
                end
            end
            default:
            begin
                clear_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            op_reg        <= OP_NONE;
            level_reg     <= '0;
            throttle_reg  <= '0;
            key_state_reg <= OP_NONE;
            stop_reg      <= 1'b0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            clear_reg     <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE:
                begin
                    if (q_valid)
                    begin
                        op_reg    <= q_item.op;
                        state_reg <= B_RUN;
                    end
                end
                B_RUN:
                begin
                    if (cord_done && !out_free)
                    begin
                        state_reg <= B_WAIT;
                    end
                end
                B_WAIT:
                begin
                    state_reg <= B_WAIT;
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
            if (commit)
            begin
                level_reg     <= level_next;
                throttle_reg  <= throttle_next;
                key_state_reg <= key_state_next;
                stop_reg      <= stop_next;
                start_reg     <= start_next;
                clear_reg     <= clear_next;
                roll_reg      <= cord_roll;
                pitch_reg     <= cord_pitch;
                out_valid_reg <= 1'b1;
                state_reg     <= B_IDLE;
            end
        end
    end

    // flag and throttle state only changes on commit, so it is the result
    assign out_valid         = out_valid_reg;
    assign roll_target       = roll_reg;
    assign pitch_target      = pitch_reg;
    assign throttle_out      = throttle_reg;
    assign key_state         = key_state_reg;
    assign stop_out          = stop_reg;
    assign start_out         = start_reg;
    assign clear_integrators = clear_reg;

endmodule

FILE: sv/rc_command_rotate_and_throttle_core.sv
// Top level of the RC command rotate and throttle block: APB registers,
// front end, request queue and back end. Depends on rcrt_pkg and submodules.
//
//   port group   direction  handshake             payload
//   in_*         in         in_valid / in_stall   roll_stick pitch_stick key_code yaw_angle
//   out_*        out        out_valid / out_stall roll_target pitch_target throttle_out
//                                                 key_state stop_out start_out clear_integrators
//   apb          in         psel penable pwrite   paddr pwdata prdata (pready tied high)
//
// In the back end a request is loaded, rotated one step per cycle, run through the shared
// gain multiplier as four partial products, has its last product added and is committed.
// The two-entry queue accepts until full while the back end works or the output stalls.
// Reset is asynchronous, active low; nothing needs a clearing pass after it.
// A held result blocks only the back end; the queue absorbs up to two more requests.
module rc_command_rotate_and_throttle_core #(
    parameter int CORDIC_ITERATIONS = rcrt_pkg::CORDIC_ITERATIONS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [rcrt_pkg::IN_W-1:0]   roll_stick,
    input  logic signed [rcrt_pkg::IN_W-1:0]   pitch_stick,
    input  logic signed [rcrt_pkg::IN_W-1:0]   key_code,
    input  logic        [rcrt_pkg::IN_W-1:0]   yaw_angle,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [rcrt_pkg::OUT_W-1:0]  roll_target,
    output logic signed [rcrt_pkg::OUT_W-1:0]  pitch_target,
    output logic [rcrt_pkg::THR_W-1:0]         throttle_out,
    output logic [rcrt_pkg::KS_W-1:0]          key_state,
    output logic                               stop_out,
    output logic                               start_out,
    output logic                               clear_integrators,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rcrt_pkg::PADDR_W-1:0]       paddr,
    input  logic [rcrt_pkg::APB_DW-1:0]        pwdata,
    output logic [rcrt_pkg::APB_DW-1:0]        prdata,
    output logic                               pready
);
    import rcrt_pkg::*;

    localparam logic REG_THROTTLE_BASE = 1'b0;
    localparam logic REG_MOTOR_OFF     = 1'b1;

    logic [THR_W-1:0] throttle_base_reg;
    logic [THR_W-1:0] motor_off_reg;
    logic             cfg_write;

    logic             push_valid;
    logic             push_ready;
    cmd_t             push_item;
    logic             q_valid;
    logic             q_pop;
    cmd_t             q_item;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            throttle_base_reg <= '0;
            motor_off_reg     <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[PADDR_W-1])
                REG_THROTTLE_BASE: throttle_base_reg <= pwdata[THR_W-1:0];
                default:           motor_off_reg     <= pwdata[THR_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        case (paddr[PADDR_W-1])
            REG_MOTOR_OFF: prdata = APB_DW'(motor_off_reg);
            default:       prdata = APB_DW'(throttle_base_reg);
        endcase
    end

    rcrt_front u_front (
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .roll_stick  (roll_stick),
        .pitch_stick (pitch_stick),
        .key_code    (key_code),
        .yaw_angle   (yaw_angle),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_item   (push_item)
    );

    rcrt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_item   (q_item)
    );

    rcrt_back #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_valid           (q_valid),
        .q_pop             (q_pop),
        .q_item            (q_item),
        .throttle_base     (throttle_base_reg),
        .motor_off_value   (motor_off_reg),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .roll_target       (roll_target),
        .pitch_target      (pitch_target),
        .throttle_out      (throttle_out),
        .key_state         (key_state),
        .stop_out          (stop_out),
        .start_out         (start_out),
        .clear_integrators (clear_integrators)
    );

endmodule

FILE: sv/rcrt_checker.sv
// Port-level checks for the RC command rotate and throttle block, bound
// to the top level. Depends on rcrt_pkg.
module rcrt_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic signed [rcrt_pkg::OUT_W-1:0]  roll_target,
    input logic signed [rcrt_pkg::OUT_W-1:0]  pitch_target,
    input logic [rcrt_pkg::THR_W-1:0]         throttle_out,
    input logic [rcrt_pkg::KS_W-1:0]          key_state,
    input logic                               stop_out,
    input logic                               start_out,
    input logic                               clear_integrators
);
    import rcrt_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(roll_target) && $stable(pitch_target)
            && $stable(throttle_out) && $stable(key_state) && $stable(clear_integrators))
        else $error("result changed while stalled");

    // a clear pulse only comes with a stop request
    a_clear_is_stop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clear_integrators |->
            stop_out && !start_out && (key_state == OP_STOP100 || key_state == OP_STOP103))
        else $error("clear pulse without stop");

    a_updown_runs: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (key_state == OP_UP || key_state == OP_DOWN) |-> !stop_out)
        else $error("stop flag set after power change");

    a_started_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && key_state == OP_START |-> start_out && stop_out)
        else $error("started state without start and stop flags");

endmodule

bind rc_command_rotate_and_throttle_core rcrt_checker u_rcrt_checker (.*);
